[rtl/bdif_pkg.sv]
// Shared constants, types and lookup functions for the box downscaler.
`default_nettype none

package bdif_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_FACTOR = 16;

    localparam int NUM_CH   = 3;
    localparam int CH_W     = 8;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int PH_W     = $clog2(MAX_FACTOR);
    localparam int FAC_W    = 5;
    localparam int DIM_W    = 11;
    localparam int SUM_W    = CH_W + 2 * PH_W;
    localparam int MEM_W    = NUM_CH * SUM_W;
    localparam int NUM_W    = SUM_W + 1;
    localparam int AREA_W   = 2 * PH_W + 1;
    localparam int RECIP_W  = 27;
    localparam int RECIP_SH = 27;
    localparam int PROD_W   = NUM_W + RECIP_W;
    localparam int IN_W     = NUM_CH * CH_W;
    localparam int RES_W    = NUM_CH * CH_W + COL_W + ROW_W;
    localparam int OUT_W    = ((RES_W + 7) / 8) * 8;
    localparam int PAD_W    = OUT_W - RES_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DIM_W;

    localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd3;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
        logic [PH_W-1:0]  fsel;
    } blk_meta_t;

    typedef struct packed {
        logic [NUM_CH-1:0][CH_W-1:0] px;
        logic                        first;
        logic                        fin;
        blk_meta_t                   meta;
    } pix_item_t;

    typedef struct packed {
        logic [NUM_CH-1:0][SUM_W-1:0] sum;
        blk_meta_t                    meta;
    } blk_sum_t;

    // ceil(2^26 / f^2), indexed by f - 1
    function automatic logic [RECIP_W-1:0] recip(input logic [PH_W-1:0] fsel);
        logic [RECIP_W-1:0] r;
        case (fsel)
            4'd0:    r = 27'd67108864;
            4'd1:    r = 27'd16777216;
            4'd2:    r = 27'd7456541;
            4'd3:    r = 27'd4194304;
            4'd4:    r = 27'd2684355;
            4'd5:    r = 27'd1864136;
            4'd6:    r = 27'd1369569;
            4'd7:    r = 27'd1048576;
            4'd8:    r = 27'd828505;
            4'd9:    r = 27'd671089;
            4'd10:   r = 27'd554619;
            4'd11:   r = 27'd466034;
            4'd12:   r = 27'd397094;
            4'd13:   r = 27'd342393;
            4'd14:   r = 27'd298262;
            default: r = 27'd262144;
        endcase
        return r;
    endfunction

    function automatic logic [AREA_W-1:0] area(input logic [PH_W-1:0] fsel);
        logic [PH_W:0]     f;
        logic [2*PH_W+1:0] sq;
        f  = {1'b0, fsel} + (PH_W+1)'(1);
        sq = f * f;
        return sq[AREA_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/box_downscale_by_integer_factor.sv]
// Top level of the integer-factor box downscaler.
// Takes one pixel per clock unless a stalled block result holds it off. A block result
// passes the accumulator stage and averager registers a, b, c, o; results leave at up
// to one per clock. The column-sum memory sets the pace: one read, one write back per pixel.
// Reset clears the counters, pipeline valids and registers (factor 1, 1x1, RGB);
// the column-sum memory is not cleared, since each block's first pixel overwrites it.
`default_nettype none

module box_downscale_by_integer_factor (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_en,
    input  wire logic [bdif_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [bdif_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  wire logic [bdif_pkg::IN_W-1:0]          s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // avg_red [7:0], avg_green [15:8], avg_blue [23:16], out_x [33:24], out_y [43:34]
    output logic [bdif_pkg::OUT_W-1:0]              m_tdata,
    output logic                                    m_tlast
);

    logic                 accept;
    logic                 item_valid;
    bdif_pkg::pix_item_t  item;
    logic                 sum_valid;
    logic                 sum_ready;
    bdif_pkg::blk_sum_t   sum;

    assign accept = s_tvalid && s_tready;

    bdif_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_en     (cfg_en),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .pix_data   (s_tdata),
        .item_valid (item_valid),
        .item       (item)
    );

    bdif_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .ready      (s_tready),
        .sum_valid  (sum_valid),
        .sum_out    (sum),
        .sum_ready  (sum_ready)
    );

    bdif_avg u_avg (
        .clk        (clk),
        .rst_n      (rst_n),
        .sum_valid  (sum_valid),
        .sum_in     (sum),
        .sum_ready  (sum_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

[rtl/bdif_ctrl.sv]
// Config registers and raster counters; one work item per pixel when factor is nonzero.
`default_nettype none

module bdif_ctrl (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_en,
    input  wire logic [bdif_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  wire logic [bdif_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                accept,
    input  wire logic [bdif_pkg::IN_W-1:0]           pix_data,
    output logic                                     item_valid,
    output bdif_pkg::pix_item_t                      item
);

    logic [bdif_pkg::FAC_W-1:0] f_reg, f_next;
    logic [bdif_pkg::DIM_W-1:0] w_reg, w_next;
    logic [bdif_pkg::DIM_W-1:0] h_reg, h_next;
    logic                       mode_reg, mode_next;

    logic [bdif_pkg::COL_W-1:0] in_col_reg, in_col_next;
    logic [bdif_pkg::ROW_W-1:0] in_row_reg, in_row_next;
    logic [bdif_pkg::PH_W-1:0]  col_ph_reg, col_ph_next;
    logic [bdif_pkg::PH_W-1:0]  row_ph_reg, row_ph_next;
    logic [bdif_pkg::COL_W-1:0] blk_col_reg, blk_col_next;
    logic [bdif_pkg::ROW_W-1:0] blk_row_reg, blk_row_next;

    logic                       f_on;
    logic [bdif_pkg::PH_W-1:0]  fsel;
    logic [bdif_pkg::DIM_W-1:0] w_eff;
    logic [bdif_pkg::DIM_W-1:0] h_eff;
    logic                       end_line;
    logic                       row_last;
    logic                       end_col;
    logic                       end_row;
    logic                       restart;

    assign f_on = (f_reg != '0);
    assign fsel = (f_reg > bdif_pkg::FAC_W'(bdif_pkg::MAX_FACTOR))
                ? bdif_pkg::PH_W'(bdif_pkg::MAX_FACTOR - 1)
                : bdif_pkg::PH_W'(f_reg - bdif_pkg::FAC_W'(1));

    assign w_eff = (w_reg == '0) ? bdif_pkg::DIM_W'(1)
                 : (w_reg > bdif_pkg::DIM_W'(bdif_pkg::MAX_WIDTH))
                 ? bdif_pkg::DIM_W'(bdif_pkg::MAX_WIDTH) : w_reg;
    assign h_eff = (h_reg == '0) ? bdif_pkg::DIM_W'(1)
                 : (h_reg > bdif_pkg::DIM_W'(bdif_pkg::MAX_HEIGHT))
                 ? bdif_pkg::DIM_W'(bdif_pkg::MAX_HEIGHT) : h_reg;

    assign end_line = (bdif_pkg::DIM_W'(in_col_reg) + bdif_pkg::DIM_W'(1)) >= w_eff;
    assign row_last = (bdif_pkg::DIM_W'(in_row_reg) + bdif_pkg::DIM_W'(1)) >= h_eff;
    assign end_col  = (col_ph_reg >= fsel) || end_line;
    assign end_row  = (row_ph_reg >= fsel) || row_last;

    assign item_valid = accept && f_on;

    always_comb
    begin
        item.px[0]     = pix_data[bdif_pkg::CH_W-1:0];
        item.px[1]     = mode_reg ? pix_data[2*bdif_pkg::CH_W-1:bdif_pkg::CH_W] : '0;
        item.px[2]     = mode_reg ? pix_data[3*bdif_pkg::CH_W-1:2*bdif_pkg::CH_W] : '0;
        item.first     = (col_ph_reg == '0) && (row_ph_reg == '0);
        item.fin       = end_col && end_row;
        item.meta.col  = blk_col_reg;
        item.meta.row  = blk_row_reg;
        item.meta.last = end_line && row_last;
        item.meta.fsel = fsel;
    end

    always_comb
    begin
        f_next       = f_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        mode_next    = mode_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        col_ph_next  = col_ph_reg;
        row_ph_next  = row_ph_reg;
        blk_col_next = blk_col_reg;
        blk_row_next = blk_row_reg;
        restart      = 1'b0;
        if (cfg_en)
        begin
            case (cfg_addr)
                bdif_pkg::REG_FACTOR:
                begin
                    f_next  = cfg_data[bdif_pkg::FAC_W-1:0];
                    restart = 1'b1;
                end
                bdif_pkg::REG_WIDTH:
                begin
                    w_next  = cfg_data;
                    restart = 1'b1;
                end
                bdif_pkg::REG_HEIGHT:
                begin
                    h_next  = cfg_data;
                    restart = 1'b1;
                end
                bdif_pkg::REG_MODE:
                begin
                    mode_next = cfg_data[0];
                    restart   = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
        else if (item_valid)
        begin
            if (end_line)
            begin
                in_col_next  = '0;
                col_ph_next  = '0;
                blk_col_next = '0;
                if (row_last)
                begin
                    in_row_next  = '0;
                    row_ph_next  = '0;
                    blk_row_next = '0;
                end
                else
                begin
                    in_row_next = in_row_reg + bdif_pkg::ROW_W'(1);
                    if (row_ph_reg >= fsel)
                    begin
                        row_ph_next  = '0;
                        blk_row_next = blk_row_reg + bdif_pkg::ROW_W'(1);
                    end
                    else
                    begin
                        row_ph_next = row_ph_reg + bdif_pkg::PH_W'(1);
                    end
                end
            end
            else
            begin
                in_col_next = in_col_reg + bdif_pkg::COL_W'(1);
                if (col_ph_reg >= fsel)
                begin
                    col_ph_next  = '0;
                    blk_col_next = blk_col_reg + bdif_pkg::COL_W'(1);
                end
                else
                begin
                    col_ph_next = col_ph_reg + bdif_pkg::PH_W'(1);
                end
            end
        end
        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            col_ph_next  = '0;
            row_ph_next  = '0;
            blk_col_next = '0;
            blk_row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_reg       <= bdif_pkg::FAC_W'(1);
            w_reg       <= bdif_pkg::DIM_W'(1);
            h_reg       <= bdif_pkg::DIM_W'(1);
            mode_reg    <= 1'b1;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            col_ph_reg  <= '0;
            row_ph_reg  <= '0;
            blk_col_reg <= '0;
            blk_row_reg <= '0;
        end
        else
        begin
            f_reg       <= f_next;
            w_reg       <= w_next;
            h_reg       <= h_next;
            mode_reg    <= mode_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            col_ph_reg  <= col_ph_next;
            row_ph_reg  <= row_ph_next;
            blk_col_reg <= blk_col_next;
            blk_row_reg <= blk_row_next;
        end
    end

    a_col_phase: assert property (@(posedge clk) disable iff (!rst_n)
        f_on |-> (col_ph_reg <= fsel))
        else $error("column phase beyond factor");

    a_row_phase: assert property (@(posedge clk) disable iff (!rst_n)
        f_on |-> (row_ph_reg <= fsel))
        else $error("row phase beyond factor");

    a_blk_col: assert property (@(posedge clk) disable iff (!rst_n)
        blk_col_reg <= in_col_reg)
        else $error("block column ahead of input column");

endmodule

`default_nettype wire

[rtl/bdif_accum.sv]
// Column-sum memory with read-modify-write and write-to-read forwarding.
`default_nettype none

module bdif_accum (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    input  wire bdif_pkg::pix_item_t  item,
    output logic                      ready,
    output logic                      sum_valid,
    output bdif_pkg::blk_sum_t        sum_out,
    input  wire logic                 sum_ready
);

    logic [bdif_pkg::MEM_W-1:0] mem [bdif_pkg::MAX_WIDTH];

    logic                                    s0_valid_reg;
    bdif_pkg::pix_item_t                     s0_item_reg;
    logic [bdif_pkg::NUM_CH-1:0][bdif_pkg::SUM_W-1:0] rd_data_reg;

    logic                                    fwd_valid_reg;
    logic [bdif_pkg::COL_W-1:0]              fwd_addr_reg;
    logic [bdif_pkg::NUM_CH-1:0][bdif_pkg::SUM_W-1:0] fwd_data_reg;

    logic                                    fwd_hit;
    logic [bdif_pkg::NUM_CH-1:0][bdif_pkg::SUM_W-1:0] base;
    logic [bdif_pkg::NUM_CH-1:0][bdif_pkg::SUM_W-1:0] sum_new;
    logic                                    wr_en;

    assign ready     = !(s0_valid_reg && s0_item_reg.fin) || sum_ready;
    assign wr_en     = s0_valid_reg && ready;
    assign fwd_hit   = fwd_valid_reg && (fwd_addr_reg == s0_item_reg.meta.col);
    assign base      = fwd_hit ? fwd_data_reg : rd_data_reg;
    assign sum_valid = s0_valid_reg && s0_item_reg.fin;

    always_comb
    begin
        for (int c = 0; c < bdif_pkg::NUM_CH; c++)
        begin
            sum_new[c] = s0_item_reg.first ? bdif_pkg::SUM_W'(s0_item_reg.px[c])
                       : base[c] + bdif_pkg::SUM_W'(s0_item_reg.px[c]);
        end
        sum_out.sum  = sum_new;
        sum_out.meta = s0_item_reg.meta;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid)
        begin
            rd_data_reg <= mem[item.meta.col];
        end
        if (wr_en)
        begin
            mem[s0_item_reg.meta.col] <= sum_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready)
        begin
            s0_item_reg  <= item;
            fwd_addr_reg <= s0_item_reg.meta.col;
            fwd_data_reg <= sum_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            s0_valid_reg  <= item_valid;
            fwd_valid_reg <= s0_valid_reg;
        end
    end

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_valid && !sum_ready) |=> (s0_valid_reg && $stable(s0_item_reg)))
        else $error("stalled block result not held");

    a_read_only_on_ready: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid |-> ready)
        else $error("pixel taken while accumulator stalled");

endmodule

`default_nettype wire

[rtl/bdif_avg.sv]
// Rounded block average by reciprocal multiply, with output register.
`default_nettype none

module bdif_avg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          sum_valid,
    input  wire bdif_pkg::blk_sum_t            sum_in,
    output logic                               sum_ready,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [bdif_pkg::OUT_W-1:0]         m_tdata,
    output logic                               m_tlast
);

    typedef logic [bdif_pkg::NUM_CH-1:0][bdif_pkg::NUM_W-1:0]  num_arr_t;
    typedef logic [bdif_pkg::NUM_CH-1:0][bdif_pkg::PROD_W-1:0] prod_arr_t;

    logic                 a_valid_reg, b_valid_reg, c_valid_reg, o_valid_reg;
    bdif_pkg::blk_sum_t   a_reg;
    num_arr_t             b_num_reg;
    bdif_pkg::blk_meta_t  b_meta_reg;
    prod_arr_t            c_prod_reg;
    bdif_pkg::blk_meta_t  c_meta_reg;
    logic [bdif_pkg::OUT_W-1:0] o_data_reg;
    logic                 o_last_reg;

    logic                 o_en, c_en, b_en, a_en;
    num_arr_t             num_next;
    prod_arr_t            prod_next;
    logic [bdif_pkg::NUM_CH-1:0][bdif_pkg::CH_W-1:0] avg;
    logic [bdif_pkg::PROD_W-bdif_pkg::RECIP_SH-1:0]  q;

    assign o_en = !o_valid_reg || m_tready;
    assign c_en = !c_valid_reg || o_en;
    assign b_en = !b_valid_reg || c_en;
    assign a_en = !a_valid_reg || b_en;
    assign sum_ready = a_en;

    always_comb
    begin
        q = '0;
        for (int c = 0; c < bdif_pkg::NUM_CH; c++)
        begin
            num_next[c]  = {a_reg.sum[c], 1'b0}
                         + bdif_pkg::NUM_W'(bdif_pkg::area(a_reg.meta.fsel));
            prod_next[c] = bdif_pkg::PROD_W'(b_num_reg[c])
                         * bdif_pkg::PROD_W'(bdif_pkg::recip(b_meta_reg.fsel));
        end
        for (int c = 0; c < bdif_pkg::NUM_CH; c++)
        begin
            q      = c_prod_reg[c][bdif_pkg::PROD_W-1:bdif_pkg::RECIP_SH];
            avg[c] = (q > (bdif_pkg::PROD_W-bdif_pkg::RECIP_SH)'(255))
                   ? bdif_pkg::CH_W'(255) : q[bdif_pkg::CH_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            a_reg <= sum_in;
        end
        if (b_en)
        begin
            b_num_reg  <= num_next;
            b_meta_reg <= a_reg.meta;
        end
        if (c_en)
        begin
            c_prod_reg <= prod_next;
            c_meta_reg <= b_meta_reg;
        end
        if (o_en)
        begin
            o_data_reg <= {bdif_pkg::PAD_W'(0), c_meta_reg.row, c_meta_reg.col,
                           avg[2], avg[1], avg[0]};
            o_last_reg <= c_meta_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_valid_reg <= sum_valid;
            end
            if (b_en)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_en)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (o_en)
            begin
                o_valid_reg <= c_valid_reg;
            end
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;
    assign m_tlast  = o_last_reg;

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && !c_en) |=> c_valid_reg)
        else $error("multiply stage dropped a block");

endmodule

`default_nettype wire
